// ----- src/sem_pkg.sv -----
// ----------------------------------------------------------------------------
// Sobel edge magnitude package
// Shared widths, constants and the pixel/job types.
// ----------------------------------------------------------------------------
package sem_pkg;
  localparam int unsigned MAX_WIDTH_DEF = 1024;
  localparam int unsigned HEIGHT_LIMIT  = 4096;
  localparam int unsigned WIDTH_W       = 11;
  localparam int unsigned HEIGHT_W      = 13;
  localparam int unsigned CFG_ADDR_W    = 1;
  localparam int unsigned CFG_DATA_W    = 13;
  localparam logic [CFG_ADDR_W-1:0] REG_WIDTH  = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_HEIGHT = 1'd1;
  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;
  localparam int unsigned SQ_W = 21;   // gx^2+gy^2 <= 2*1020^2

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  typedef struct packed {
    pixel_t [8:0] win;
    logic         interior;
    logic         last;
  } job_t;
endpackage

// ----- src/sem_stream_if.sv -----
// ----------------------------------------------------------------------------
// Pixel stream interface
// Valid/ready channel carrying an RGBA pixel plus one flag bit.
// ----------------------------------------------------------------------------
interface sem_stream_if;
  logic           valid;
  logic           ready;
  sem_pkg::pixel_t pix;
  logic           flag;
  modport source (output valid, output pix, output flag, input ready);
  modport sink   (input valid, input pix, input flag, output ready);
endinterface

// ----- src/sobel_edge_magnitude_core.sv -----
// ----------------------------------------------------------------------------
// Sobel edge magnitude core
// Front end: accepts a new pixel only after the line-store write of the last
// one has landed; back end: takes a job only when idle, after the bit-serial
// square root and output of the previous job (queue of 4 jobs absorbs bursts).
// Reset: synchronous active low; counters, window and queue clear, line
// stores hold unknown contents until written.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_core #(
  parameter int unsigned MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic                            cfg_we,
  input  logic [sem_pkg::CFG_ADDR_W-1:0]  cfg_index,
  input  logic [sem_pkg::CFG_DATA_W-1:0]  cfg_data,
  sem_stream_if.sink   in_ch,
  sem_stream_if.source out_ch
);
  logic [sem_pkg::WIDTH_W-1:0]  w_r;
  logic [sem_pkg::HEIGHT_W-1:0] h_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= sem_pkg::WIDTH_RESET;
      h_r <= sem_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        sem_pkg::REG_WIDTH:  w_r <= cfg_data[sem_pkg::WIDTH_W-1:0];
        sem_pkg::REG_HEIGHT: h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic busy, job_valid, take, empty, in_fire;
  logic [2:0] cnt;
  sem_pkg::job_t job, qd;

  // a job may still be in the front pipe; keep room for it
  assign in_ch.ready = !busy && (cnt <= 3'd1);
  assign in_fire     = in_ch.valid && in_ch.ready;

  sem_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk(clk), .rst_n(rst_n), .cfg_w(w_r), .cfg_h(h_r),
    .in_fire(in_fire), .in_pix(in_ch.pix), .in_pad(in_ch.flag),
    .busy(busy), .job_valid(job_valid), .job(job)
  );
  sem_fifo #(.DEPTH(4)) u_fifo (
    .clk(clk), .rst_n(rst_n), .push(job_valid), .din(job),
    .pop(take), .empty(empty), .count(cnt), .dout(qd)
  );
  sem_back u_back (
    .clk(clk), .rst_n(rst_n), .job_valid(!empty), .job(qd),
    .job_take(take), .out_ch(out_ch)
  );
endmodule

// ----- src/sem_ram.sv -----
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write and one read port, registered read data.
// ----------------------------------------------------------------------------
module sem_ram #(
  parameter int unsigned DATA_W = 32,
  parameter int unsigned DEPTH  = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);
  logic [DATA_W-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

// ----- src/sem_front.sv -----
// ----------------------------------------------------------------------------
// Sobel front end
// Counts position, reads/writes line stores, shifts the 3x3 window and
// emits classified jobs. Two stage: address/read, then window update.
// ----------------------------------------------------------------------------
module sem_front #(
  parameter int unsigned MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [sem_pkg::WIDTH_W-1:0]   cfg_w,
  input  logic [sem_pkg::HEIGHT_W-1:0]  cfg_h,
  input  logic                          in_fire,
  input  sem_pkg::pixel_t               in_pix,
  input  logic                          in_pad,
  output logic                          busy,
  output logic                          job_valid,
  output sem_pkg::job_t                 job
);
  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned CW = sem_pkg::WIDTH_W;
  localparam int unsigned RW = sem_pkg::HEIGHT_W + 1;

  logic [CW-1:0] w_eff;
  logic [RW-1:0] h_eff;
  always_comb begin
    w_eff = cfg_w;
    if (cfg_w == '0) w_eff = CW'(1);
    if (32'(cfg_w) > MAX_WIDTH) w_eff = CW'(MAX_WIDTH);
    h_eff = RW'(cfg_h);
    if (cfg_h == '0) h_eff = RW'(1);
    if (32'(cfg_h) > sem_pkg::HEIGHT_LIMIT) h_eff = RW'(sem_pkg::HEIGHT_LIMIT);
  end

  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] c0, c;
  logic [RW-1:0] r0, r;
  logic [CW-1:0] ox;
  logic [RW-1:0] oy;
  logic          emit, last_px, wrap;

  always_comb begin
    c0 = col_r;
    r0 = row_r;
    if (c0 >= w_eff) begin
      c0 = '0;
      r0 = r0 + RW'(1);
    end
    if (r0 > h_eff + RW'(1)) begin
      c0 = '0;
      r0 = '0;
    end
    r = r0;
    c = (32'(c0) >= MAX_WIDTH) ? CW'(MAX_WIDTH - 1) : c0;
    emit = 1'b1;
    if (c >= CW'(1)) begin
      ox = c - CW'(1);
      oy = r - RW'(1);
      if (r < RW'(1)) emit = 1'b0;
    end else begin
      ox = w_eff - CW'(1);
      oy = r - RW'(2);
      if (r < RW'(2)) emit = 1'b0;
    end
    if (oy >= h_eff) emit = 1'b0;
    last_px = emit && (ox == w_eff - CW'(1)) && (oy == h_eff - RW'(1));
    col_nxt = c + CW'(1);
    row_nxt = r;
    wrap = col_nxt >= w_eff;
    if (wrap) begin
      col_nxt = '0;
      row_nxt = r + RW'(1);
    end
    if (last_px) begin
      col_nxt = '0;
      row_nxt = '0;
    end
  end

  logic          s1_v_r, s1d_r;
  logic          s1_emit_r, s1_last_r, s1_int_r;
  sem_pkg::pixel_t s1_px_r;
  logic [31:0]   up_rd, mid_rd;
  logic          interior;

  assign interior = (ox >= CW'(1)) && ((RW'(ox) + RW'(2)) <= RW'(w_eff))
                    && (oy >= RW'(1)) && (oy + RW'(2) <= h_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      s1_v_r <= 1'b0;
      s1d_r  <= 1'b0;
    end else begin
      s1_v_r <= in_fire;
      s1d_r  <= s1_v_r;
      if (in_fire) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_px_r   <= in_pad ? '0 : in_pix;
      s1_emit_r <= emit;
      s1_last_r <= last_px;
      s1_int_r  <= interior;
    end
  end

  // read-before-write on each store: write the same column next
  // cycle from the registered data (busy holds the next item off until the
  // write has landed)
  logic [AW-1:0] addr_r;
  always_ff @(posedge clk) begin
    if (in_fire) addr_r <= c[AW-1:0];
  end

  sem_ram #(.DATA_W(32), .DEPTH(MAX_WIDTH)) u_up (
    .clk(clk), .we(s1_v_r), .waddr(addr_r), .wdata(mid_rd),
    .re(in_fire), .raddr(c[AW-1:0]), .rdata(up_rd)
  );
  sem_ram #(.DATA_W(32), .DEPTH(MAX_WIDTH)) u_mid (
    .clk(clk), .we(s1_v_r), .waddr(addr_r), .wdata(s1_px_r),
    .re(in_fire), .raddr(c[AW-1:0]), .rdata(mid_rd)
  );

  sem_pkg::pixel_t [8:0] win_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (s1_v_r) begin
      for (int k = 0; k < 3; k++) begin
        win_r[3*k]   <= win_r[3*k+1];
        win_r[3*k+1] <= win_r[3*k+2];
      end
      win_r[2] <= up_rd;
      win_r[5] <= mid_rd;
      win_r[8] <= s1_px_r;
    end
  end

  logic s2_v_r, s2_int_r, s2_last_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else        s2_v_r <= s1_v_r && s1_emit_r;
  end
  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      s2_int_r  <= s1_int_r;
      s2_last_r <= s1_last_r;
    end
  end

  assign busy          = s1_v_r || s1d_r;
  assign job_valid     = s2_v_r;
  assign job.win       = win_r;
  assign job.interior  = s2_int_r;
  assign job.last      = s2_last_r;
endmodule

// ----- src/sem_fifo.sv -----
// ----------------------------------------------------------------------------
// Job queue
// Small register FIFO between front and back ends.
// ----------------------------------------------------------------------------
module sem_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  sem_pkg::job_t din,
  input  logic          pop,
  output logic          empty,
  output logic [$clog2(DEPTH):0] count,
  output sem_pkg::job_t dout
);
  localparam int unsigned PW = $clog2(DEPTH);
  sem_pkg::job_t mem_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + PW'(1);
      if (pop)  rp_r <= rp_r + PW'(1);
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= din;
  end
  assign empty = (cnt_r == '0);
  assign count = cnt_r;
  assign dout  = mem_r[rp_r];
endmodule

// ----- src/sem_back.sv -----
// ----------------------------------------------------------------------------
// Sobel back end
// Gradients, squared magnitude, bit-serial rounded square root per channel.
// ----------------------------------------------------------------------------
module sem_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          job_valid,
  input  sem_pkg::job_t job,
  output logic          job_take,
  sem_stream_if.source  out_ch
);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SQ   = 2'd1;
  localparam logic [1:0] ST_ROOT = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0] st_r;
  logic [3:0] it_r;
  sem_pkg::job_t j_r;
  logic signed [10:0] gx_r [3], gy_r [3];
  logic [sem_pkg::SQ_W+1:0] s_r [3];   // 4*s, remainder
  logic [11:0] q_r [3];                // root of 4s, yields 2n+1 bound
  logic [7:0]  res [3];

  function automatic logic signed [10:0] ch(input sem_pkg::pixel_t p, input int i);
    logic [7:0] v;
    v = (i == 0) ? p.red : (i == 1) ? p.green : p.blue;
    return 11'(v);
  endfunction

  assign job_take = (st_r == ST_IDLE) && job_valid;

  // isqrt of 4s gives m=floor(2*sqrt(s)); n = ceil-tie = floor((m+1)/2)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      it_r <= '0;
    end else begin
      case (st_r)
        ST_IDLE: if (job_valid) st_r <= ST_SQ;
        ST_SQ: begin
          st_r <= ST_ROOT;
          it_r <= 4'd11;
        end
        ST_ROOT: if (it_r == 4'd0) st_r <= ST_OUT;
                 else it_r <= it_r - 4'd1;
        ST_OUT: if (out_ch.ready) st_r <= ST_IDLE;
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (job_take) begin
      j_r <= job;
      for (int i = 0; i < 3; i++) begin
        gx_r[i] <= (ch(job.win[2], i) + (ch(job.win[5], i) <<< 1) + ch(job.win[8], i))
                 - (ch(job.win[0], i) + (ch(job.win[3], i) <<< 1) + ch(job.win[6], i));
        gy_r[i] <= (ch(job.win[0], i) + (ch(job.win[1], i) <<< 1) + ch(job.win[2], i))
                 - (ch(job.win[6], i) + (ch(job.win[7], i) <<< 1) + ch(job.win[8], i));
      end
    end
    if (st_r == ST_SQ) begin
      for (int i = 0; i < 3; i++) begin
        s_r[i] <= ((sem_pkg::SQ_W+2)'(gx_r[i] * gx_r[i])
                 + (sem_pkg::SQ_W+2)'(gy_r[i] * gy_r[i])) << 2;
        q_r[i] <= '0;
      end
    end
    if (st_r == ST_ROOT) begin
      for (int i = 0; i < 3; i++) begin
        logic [23:0] t;
        logic [23:0] cand;
        t = 24'(q_r[i]) << (it_r + 5'd1);
        cand = t + (24'd1 << (5'(it_r) << 1));
        if (24'(s_r[i]) >= cand) begin
          s_r[i] <= (sem_pkg::SQ_W+2)'(24'(s_r[i]) - cand);
          q_r[i] <= q_r[i] | (12'd1 << it_r);
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [12:0] n;
      n = (13'(q_r[i]) + 13'd1) >> 1;
      res[i] = (n > 13'd255) ? 8'd255 : n[7:0];
    end
  end

  assign out_ch.valid     = (st_r == ST_OUT);
  assign out_ch.pix.red   = j_r.interior ? res[0] : j_r.win[4].red;
  assign out_ch.pix.green = j_r.interior ? res[1] : j_r.win[4].green;
  assign out_ch.pix.blue  = j_r.interior ? res[2] : j_r.win[4].blue;
  assign out_ch.pix.alpha = j_r.win[4].alpha;
  assign out_ch.flag      = j_r.last;
endmodule

// ----- src/sem_checker.sv -----
// ----------------------------------------------------------------------------
// Sobel core port checker
// Port level properties, bound to the top level.
// ----------------------------------------------------------------------------
module sem_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [7:0] out_red
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("out dropped");
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_red)) else $error("out changed");
  a_no_b2b: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("ready after accept");
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("valid after reset");
endmodule

bind sobel_edge_magnitude_core sem_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_red(out_ch.pix.red)
);

// ----- test/sobel_edge_magnitude_checker.sv -----
// ----------------------------------------------------------------------------
// Sobel edge magnitude checker
// Watches the configuration port and both pixel channels, predicts each
// result transaction from a local line store and window model, and compares
// every output transaction field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [sem_pkg::CFG_ADDR_W-1:0] cfg_index,
  input  logic [sem_pkg::CFG_DATA_W-1:0] cfg_data,
  sem_stream_if                          in_mon,
  sem_stream_if                          out_mon,
  output int                             errors,
  output int                             pending,
  output int                             checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    sem_pkg::pixel_t pix;
    logic            last;
  } edge_px_t;

  localparam int unsigned MAXW = sem_pkg::MAX_WIDTH_DEF;

  sem_pkg::pixel_t upper_line [MAXW];
  sem_pkg::pixel_t middle_line[MAXW];
  sem_pkg::pixel_t win[9];
  int unsigned     col_pos, row_pos;
  logic [sem_pkg::WIDTH_W-1:0]  width_reg;
  logic [sem_pkg::HEIGHT_W-1:0] height_reg;
  edge_px_t        expected_px[$];

  function automatic int unsigned eff_w();
    int unsigned w;
    w = width_reg;
    if (w == 0) w = 1;
    if (w > MAXW) w = MAXW;
    return w;
  endfunction

  function automatic int unsigned eff_h();
    int unsigned h;
    h = height_reg;
    if (h == 0) h = 1;
    if (h > sem_pkg::HEIGHT_LIMIT) h = sem_pkg::HEIGHT_LIMIT;
    return h;
  endfunction

  // smallest n with 4s < (2n+1)^2, saturated to 255
  function automatic logic [7:0] round_root(longint s);
    longint r, b, t;
    r = 0;
    for (b = 1024; b > 0; b = b / 2) begin
      t = 2 * (r + b) - 1;
      if (t * t <= 4 * s) r = r + b;
    end
    return (r > 255) ? 8'd255 : r[7:0];
  endfunction

  function automatic logic [7:0] grad_mag(int sh);
    int v[9];
    int gx, gy;
    for (int i = 0; i < 9; i++) v[i] = (win[i] >> sh) & 8'hFF;
    gx = (v[2] + 2 * v[5] + v[8]) - (v[0] + 2 * v[3] + v[6]);
    gy = (v[0] + 2 * v[1] + v[2]) - (v[6] + 2 * v[7] + v[8]);
    return round_root(longint'(gx * gx) + longint'(gy * gy));
  endfunction

  task automatic advance_window(input sem_pkg::pixel_t p, input logic pad);
    int unsigned w, h, c, r, ox, oy;
    sem_pkg::pixel_t px, up, mid, ctr;
    edge_px_t e;
    w = eff_w();
    h = eff_h();
    if (col_pos >= w) begin col_pos = 0; row_pos++; end
    if (row_pos > h + 1) begin col_pos = 0; row_pos = 0; end
    c = col_pos;
    r = row_pos;
    px = pad ? '0 : p;
    if (c >= MAXW) c = MAXW - 1;
    up = upper_line[c];
    mid = middle_line[c];
    upper_line[c] = mid;
    middle_line[c] = px;
    for (int k = 0; k < 3; k++) begin
      win[3*k]   = win[3*k+1];
      win[3*k+1] = win[3*k+2];
    end
    win[2] = up;
    win[5] = mid;
    win[8] = px;
    col_pos++;
    if (col_pos >= w) begin col_pos = 0; row_pos++; end
    if (c >= 1) begin
      if (r < 1) return;
      ox = c - 1;
      oy = r - 1;
    end else begin
      if (r < 2) return;
      ox = w - 1;
      oy = r - 2;
    end
    if (oy >= h) return;
    ctr = win[4];
    e.pix = ctr;
    if (ox >= 1 && ox + 2 <= w && oy >= 1 && oy + 2 <= h) begin
      e.pix.red   = grad_mag(0);
      e.pix.green = grad_mag(8);
      e.pix.blue  = grad_mag(16);
    end
    e.last = 1'b0;
    if (ox == w - 1 && oy == h - 1) begin
      e.last = 1'b1;
      col_pos = 0;
      row_pos = 0;
    end
    expected_px.push_back(e);
  endtask

  always @(posedge clk) begin
    edge_px_t e;
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) win[i] = '0;
      col_pos = 0;
      row_pos = 0;
      width_reg = sem_pkg::WIDTH_RESET;
      height_reg = sem_pkg::HEIGHT_RESET;
      expected_px.delete();
      errors = 0;
      checked = 0;
      pending = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_px.size() == 0) begin
          $display("%0t: unexpected result transaction: actual %h last %b", $time,
                   out_mon.pix, out_mon.flag);
          errors++;
        end else begin
          e = expected_px.pop_front();
          checked++;
          if (out_mon.pix.red !== e.pix.red) begin
            $display("%0t: red mismatch: expected %h actual %h", $time,
                     e.pix.red, out_mon.pix.red);
            errors++;
          end
          if (out_mon.pix.green !== e.pix.green) begin
            $display("%0t: green mismatch: expected %h actual %h", $time,
                     e.pix.green, out_mon.pix.green);
            errors++;
          end
          if (out_mon.pix.blue !== e.pix.blue) begin
            $display("%0t: blue mismatch: expected %h actual %h", $time,
                     e.pix.blue, out_mon.pix.blue);
            errors++;
          end
          if (out_mon.pix.alpha !== e.pix.alpha) begin
            $display("%0t: alpha mismatch: expected %h actual %h", $time,
                     e.pix.alpha, out_mon.pix.alpha);
            errors++;
          end
          if (out_mon.flag !== e.last) begin
            $display("%0t: frame_last mismatch: expected %b actual %b", $time,
                     e.last, out_mon.flag);
            errors++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) advance_window(in_mon.pix, in_mon.flag);
      if (cfg_we) begin
        if (cfg_index == sem_pkg::REG_WIDTH) begin
          width_reg = cfg_data[sem_pkg::WIDTH_W-1:0];
        end else if (cfg_index == sem_pkg::REG_HEIGHT) begin
          height_reg = cfg_data[sem_pkg::HEIGHT_W-1:0];
        end
      end
      pending = expected_px.size();
    end
  end
endmodule

// ----- test/sobel_edge_magnitude_core_tb.sv -----
// ----------------------------------------------------------------------------
// Sobel edge magnitude core testbench
// Streams whole frames (pixels plus flush items) through the core across a
// range of frame sizes, including out-of-range register values, with random
// stalls on both channels and one long output hold-off. A separate checker
// predicts and compares every result transaction.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk;
  logic rst_n;
  logic                           cfg_we;
  logic [sem_pkg::CFG_ADDR_W-1:0] cfg_index;
  logic [sem_pkg::CFG_DATA_W-1:0] cfg_data;
  int errors, pending, checked;
  int sent_items, frames_sent;
  int src_idle_pct, sink_idle_pct;
  bit long_hold;
  bit hold_done;

  sem_stream_if in_ch ();
  sem_stream_if out_ch ();

  sobel_edge_magnitude_core dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  sobel_edge_magnitude_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_mon(in_ch), .out_mon(out_ch),
    .errors(errors), .pending(pending), .checked(checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #30ms;
    $display("TEST FAILED");
    $finish;
  end

  // result side back-pressure
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(negedge clk);
        long_hold = 1'b0;
      end
      out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  task automatic set_idling();
    if (sent_items < 450) begin
      src_idle_pct = 34; sink_idle_pct = 76;
    end else if (sent_items < 900) begin
      src_idle_pct = 76; sink_idle_pct = 34;
    end else begin
      src_idle_pct = 0; sink_idle_pct = 0;
    end
  endtask

  // called and returns at a falling edge
  task automatic put_pixel(input sem_pkg::pixel_t p, input logic pad);
    set_idling();
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.pix   <= p;
    in_ch.flag  <= pad;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent_items++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [sem_pkg::CFG_ADDR_W-1:0] idx,
                           input int unsigned val);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[sem_pkg::CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [7:0] chan_val(int mode);
    case (mode)
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // mode 0: random, 1: stripes of 0/FF, 2: random with pads mixed in
  task automatic send_frame(input int unsigned w, input int unsigned h, input int mode);
    sem_pkg::pixel_t p;
    int unsigned n, x;
    n = w * h;
    for (int unsigned i = 0; i < n + w + 1; i++) begin
      x = i % w;
      if (mode == 1) begin
        p.red   = x[0] ? 8'hFF : 8'h00;
        p.green = (i / w) % 2 ? 8'hFF : 8'h00;
        p.blue  = (x + i / w) % 2 ? 8'h00 : 8'hFF;
        p.alpha = x[0] ? 8'h00 : 8'hFF;
      end else begin
        p.red   = chan_val($urandom_range(3));
        p.green = chan_val($urandom_range(3));
        p.blue  = chan_val($urandom_range(3));
        p.alpha = chan_val($urandom_range(3));
      end
      if (i < n) put_pixel(p, (mode == 2) && ($urandom_range(19) == 0));
      else put_pixel(p, !((mode == 2) && ($urandom_range(3) == 0)));
    end
    frames_sent++;
  endtask

  task automatic frame_size(input int unsigned wr, input int unsigned hr);
    write_reg(sem_pkg::REG_WIDTH, wr);
    write_reg(sem_pkg::REG_HEIGHT, hr);
  endtask

  initial begin
    int unsigned w, h;
    sem_pkg::pixel_t p;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.pix = '0;
    in_ch.flag = 1'b0;
    sent_items = 0;
    frames_sent = 0;
    long_hold = 1'b0;
    hold_done = 1'b0;
    set_idling();
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed frames
    frame_size(3, 3);
    send_frame(3, 3, 1);
    frame_size(0, 0);
    send_frame(1, 1, 0);
    frame_size(2, 2);
    send_frame(2, 2, 2);

    // random frames, mostly small
    while (sent_items < 1200) begin
      w = ($urandom_range(9) == 0) ? $urandom_range(40, 1) : $urandom_range(12, 1);
      h = $urandom_range(8, 1);
      frame_size(w, h);
      if (!hold_done && sent_items > 500) begin
        long_hold = 1'b1;
        hold_done = 1'b1;
      end
      repeat ($urandom_range(3, 1)) send_frame(w, h, ($urandom_range(3) == 0) ? 0 : 2);
    end

    // clamped register values, a partial row, then a size change mid-frame
    frame_size(2047, 8191);
    for (int unsigned i = 0; i < 100; i++) begin
      p = sem_pkg::pixel_t'($urandom());
      put_pixel(p, 1'b0);
    end
    frame_size(5, 4);
    send_frame(5, 4, 2);

    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    $display("Sent %0d pixel and flush items in %0d frames; %0d results compared.",
             sent_items, frames_sent, checked);
    $display("Frames from 1x1 up to 40x8 plus clamped sizes and a mid-frame change,");
    $display("with stalls on both sides and one long result hold-off.");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
